### hw/rtl/luma_motion_vector_predictor_core_defines.svh
// Assertion macros shared by the motion vector predictor RTL.
`ifndef LUMA_MOTION_VECTOR_PREDICTOR_CORE_DEFINES_SVH
`define LUMA_MOTION_VECTOR_PREDICTOR_CORE_DEFINES_SVH

// General clocked property, disabled during reset.
`define LMVP_ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lmvp assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define LMVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmvp assertion failed");

`endif

### hw/rtl/lmvp_pkg.sv
// Types, constants and helper functions for the luma motion vector predictor.
`default_nettype none

package lmvp_pkg;

  localparam int unsigned MvW      = 16;
  localparam int unsigned RefW     = 4;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned NbrW     = 38;
  localparam int unsigned ShapeW   = 3;
  localparam int unsigned IndexW   = 2;
  localparam int unsigned AvailBit = 37;

  typedef enum logic [ShapeW-1:0] {
    SHAPE_16X16 = 3'd0,
    SHAPE_16X8  = 3'd1,
    SHAPE_8X16  = 3'd2,
    SHAPE_8X8   = 3'd3,
    SHAPE_8X4   = 3'd4,
    SHAPE_4X8   = 3'd5,
    SHAPE_4X4   = 3'd6,
    SHAPE_SKIP  = 3'd7
  } shape_t;

  // Reference code 1 means reference index 0; code 0 means no reference.
  localparam logic [CodeW-1:0] CodeRef0 = 5'd1;

  typedef struct packed {
    logic                  avail;
    logic [CodeW-1:0]      code;
    logic signed [MvW-1:0] mx;
    logic signed [MvW-1:0] my;
  } nbr_t;

  typedef struct packed {
    logic skip_zero;
  } calc_status_t;

  // Unavailable or intra neighbors carry a zero vector and a code that never matches.
  function automatic nbr_t unpack_nbr(logic [NbrW-1:0] w);
    nbr_t n;
    n.avail = w[AvailBit];
    n.code  = w[36:32];
    n.mx    = w[15:0];
    n.my    = w[31:16];
    if (!n.avail || n.code == '0) begin
      n.code = '0;
      n.mx   = '0;
      n.my   = '0;
    end
    return n;
  endfunction

  function automatic logic signed [MvW-1:0] med3(logic signed [MvW-1:0] a,
                                                 logic signed [MvW-1:0] b,
                                                 logic signed [MvW-1:0] c);
    logic signed [MvW-1:0] lo;
    logic signed [MvW-1:0] hi;
    logic signed [MvW-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (c < hi) ? c : hi;
    return (lo > m) ? lo : m;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lmvp_calc.sv
// Combinational predictor selection, median and difference add for one partition.
`default_nettype none

module lmvp_calc (
  input  wire logic [lmvp_pkg::ShapeW-1:0]   partition_shape,
  input  wire logic [lmvp_pkg::IndexW-1:0]   part_index,
  input  wire logic [lmvp_pkg::RefW-1:0]     current_ref,
  input  wire logic signed [lmvp_pkg::MvW-1:0] mvd_x,
  input  wire logic signed [lmvp_pkg::MvW-1:0] mvd_y,
  input  wire logic [lmvp_pkg::NbrW-1:0]     nbr_a,
  input  wire logic [lmvp_pkg::NbrW-1:0]     nbr_b,
  input  wire logic [lmvp_pkg::NbrW-1:0]     nbr_c,
  input  wire logic [lmvp_pkg::NbrW-1:0]     nbr_d,
  output logic signed [lmvp_pkg::MvW-1:0]    pred_x,
  output logic signed [lmvp_pkg::MvW-1:0]    pred_y,
  output logic signed [lmvp_pkg::MvW-1:0]    mv_x,
  output logic signed [lmvp_pkg::MvW-1:0]    mv_y,
  output lmvp_pkg::calc_status_t             status
);

  lmvp_pkg::nbr_t              a;
  lmvp_pkg::nbr_t              b;
  lmvp_pkg::nbr_t              c;
  lmvp_pkg::nbr_t              bm;
  lmvp_pkg::nbr_t              cm;
  lmvp_pkg::nbr_t              dir;
  lmvp_pkg::nbr_t              single;
  logic                        skip;
  logic                        zero;
  logic                        idx;
  logic                        dir_en;
  logic                        dir_hit;
  logic                        ma;
  logic                        mb;
  logic                        mc;
  logic                        single_hit;
  logic [lmvp_pkg::CodeW-1:0]  cur;
  logic signed [lmvp_pkg::MvW-1:0] dx;
  logic signed [lmvp_pkg::MvW-1:0] dy;

  always_comb begin
    a    = lmvp_pkg::unpack_nbr(nbr_a);
    b    = lmvp_pkg::unpack_nbr(nbr_b);
    c    = nbr_c[lmvp_pkg::AvailBit] ? lmvp_pkg::unpack_nbr(nbr_c)
                                     : lmvp_pkg::unpack_nbr(nbr_d);
    idx  = part_index[0];
    skip = (lmvp_pkg::shape_t'(partition_shape) == lmvp_pkg::SHAPE_SKIP);
    cur  = skip ? lmvp_pkg::CodeRef0
                : {1'b0, current_ref} + lmvp_pkg::CodeRef0;
    dx   = skip ? '0 : mvd_x;
    dy   = skip ? '0 : mvd_y;

    zero = skip && (!a.avail || !b.avail ||
                    (a.code == lmvp_pkg::CodeRef0 && a.mx == '0 && a.my == '0) ||
                    (b.code == lmvp_pkg::CodeRef0 && b.mx == '0 && b.my == '0));

    dir    = a;
    dir_en = 1'b0;
    case (lmvp_pkg::shape_t'(partition_shape))
      lmvp_pkg::SHAPE_16X8, lmvp_pkg::SHAPE_8X4: begin
        dir    = idx ? a : b;
        dir_en = 1'b1;
      end
      lmvp_pkg::SHAPE_8X16, lmvp_pkg::SHAPE_4X8: begin
        dir    = idx ? c : a;
        dir_en = 1'b1;
      end
      default: begin
        dir    = a;
        dir_en = 1'b0;
      end
    endcase
    dir_hit = dir_en && (dir.code == cur);

    // When only the left neighbor exists, it stands in for the two above.
    if (!b.avail && !c.avail && a.avail) begin
      bm = a;
      cm = a;
    end else begin
      bm = b;
      cm = c;
    end
    ma = (a.code == cur);
    mb = (bm.code == cur);
    mc = (cm.code == cur);
    single_hit = (ma && !mb && !mc) || (!ma && mb && !mc) || (!ma && !mb && mc);
    single     = ma ? a : (mb ? bm : cm);

    if (zero) begin
      pred_x = '0;
      pred_y = '0;
    end else if (dir_hit) begin
      pred_x = dir.mx;
      pred_y = dir.my;
    end else if (single_hit) begin
      pred_x = single.mx;
      pred_y = single.my;
    end else begin
      pred_x = lmvp_pkg::med3(a.mx, bm.mx, cm.mx);
      pred_y = lmvp_pkg::med3(a.my, bm.my, cm.my);
    end

    mv_x = pred_x + dx;
    mv_y = pred_y + dy;

    status.skip_zero = zero;
  end

endmodule

`default_nettype wire

### hw/rtl/luma_motion_vector_predictor_core.sv
// Top level of the luma motion vector predictor: request register, predictor, result register.
// The request register and in_vld load at the accepting edge; done and the result register load together from in_vld.
// Throughput: one request per cycle; busy is never raised, the path is fully pipelined.
// The work sits between the request register and the result register in one pass.
// Each result is flagged by done for exactly one cycle; the receiver cannot stall.
// Reset clears the valid flags only; no request is in flight after reset.
`default_nettype none
`include "luma_motion_vector_predictor_core_defines.svh"

module luma_motion_vector_predictor_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [lmvp_pkg::ShapeW-1:0]     partition_shape,
  input  wire logic [lmvp_pkg::IndexW-1:0]     part_index,
  input  wire logic [lmvp_pkg::RefW-1:0]       current_ref,
  input  wire logic signed [lmvp_pkg::MvW-1:0] mvd_x,
  input  wire logic signed [lmvp_pkg::MvW-1:0] mvd_y,
  input  wire logic [lmvp_pkg::NbrW-1:0]       nbr_a,
  input  wire logic [lmvp_pkg::NbrW-1:0]       nbr_b,
  input  wire logic [lmvp_pkg::NbrW-1:0]       nbr_c,
  input  wire logic [lmvp_pkg::NbrW-1:0]       nbr_d,
  output logic                                 done,
  output logic signed [lmvp_pkg::MvW-1:0]      pred_x,
  output logic signed [lmvp_pkg::MvW-1:0]      pred_y,
  output logic signed [lmvp_pkg::MvW-1:0]      mv_x,
  output logic signed [lmvp_pkg::MvW-1:0]      mv_y
);

  logic                              in_vld;
  logic [lmvp_pkg::ShapeW-1:0]       shape_q;
  logic [lmvp_pkg::IndexW-1:0]       index_q;
  logic [lmvp_pkg::RefW-1:0]         ref_q;
  logic signed [lmvp_pkg::MvW-1:0]   mvd_x_q;
  logic signed [lmvp_pkg::MvW-1:0]   mvd_y_q;
  logic [lmvp_pkg::NbrW-1:0]         nbr_a_q;
  logic [lmvp_pkg::NbrW-1:0]         nbr_b_q;
  logic [lmvp_pkg::NbrW-1:0]         nbr_c_q;
  logic [lmvp_pkg::NbrW-1:0]         nbr_d_q;
  logic signed [lmvp_pkg::MvW-1:0]   pred_x_next;
  logic signed [lmvp_pkg::MvW-1:0]   pred_y_next;
  logic signed [lmvp_pkg::MvW-1:0]   mv_x_next;
  logic signed [lmvp_pkg::MvW-1:0]   mv_y_next;
  lmvp_pkg::calc_status_t            calc_status;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= start && !busy;
      done   <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      shape_q <= partition_shape;
      index_q <= part_index;
      ref_q   <= current_ref;
      mvd_x_q <= mvd_x;
      mvd_y_q <= mvd_y;
      nbr_a_q <= nbr_a;
      nbr_b_q <= nbr_b;
      nbr_c_q <= nbr_c;
      nbr_d_q <= nbr_d;
    end
    if (in_vld) begin
      pred_x <= pred_x_next;
      pred_y <= pred_y_next;
      mv_x   <= mv_x_next;
      mv_y   <= mv_y_next;
    end
  end

  lmvp_calc u_calc (
    .partition_shape (shape_q),
    .part_index      (index_q),
    .current_ref     (ref_q),
    .mvd_x           (mvd_x_q),
    .mvd_y           (mvd_y_q),
    .nbr_a           (nbr_a_q),
    .nbr_b           (nbr_b_q),
    .nbr_c           (nbr_c_q),
    .nbr_d           (nbr_d_q),
    .pred_x          (pred_x_next),
    .pred_y          (pred_y_next),
    .mv_x            (mv_x_next),
    .mv_y            (mv_y_next),
    .status          (calc_status)
  );

  `LMVP_ASSERT_PROP(a_latency, (start && !busy) |=> ##1 done)
  `LMVP_ASSERT_NEXT(a_skip_zero, in_vld && calc_status.skip_zero,
                    pred_x == '0 && pred_y == '0 && mv_x == '0 && mv_y == '0)
  `LMVP_ASSERT_NEXT(a_skip_mv, in_vld && lmvp_pkg::shape_t'(shape_q) == lmvp_pkg::SHAPE_SKIP,
                    mv_x == pred_x && mv_y == pred_y)
  `LMVP_ASSERT_NEXT(a_mvd_add,
                    in_vld && lmvp_pkg::shape_t'(shape_q) != lmvp_pkg::SHAPE_SKIP,
                    lmvp_pkg::MvW'(mv_x - pred_x) == $past(mvd_x_q) &&
                    lmvp_pkg::MvW'(mv_y - pred_y) == $past(mvd_y_q))

endmodule

`default_nettype wire
